// ===== rtl/lcdn_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types, codes and the request script table for the 4-bit LCD
// interface.
// ----------------------------------------------------------------------------
package lcdn_pkg;

  localparam logic [2:0] OP_CMD   = 3'd0;
  localparam logic [2:0] OP_DATA  = 3'd1;
  localparam logic [2:0] OP_INIT  = 3'd2;
  localparam logic [2:0] OP_CURS  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_SHR   = 3'd5;
  localparam logic [2:0] OP_SHL   = 3'd6;
  localparam logic [2:0] OP_NONE  = 3'd7;

  localparam logic [1:0] REG_PULSE = 2'd0;
  localparam logic [1:0] REG_PWRUP = 2'd1;
  localparam logic [1:0] REG_CLEAR = 2'd2;

  localparam logic [7:0] PULSE_RST = 8'd1;
  localparam logic [7:0] PWRUP_RST = 8'd50;
  localparam logic [7:0] CLEAR_RST = 8'd1;

  localparam logic [7:0] B_HOME    = 8'h02;
  localparam logic [7:0] B_FUNC    = 8'h28;
  localparam logic [7:0] B_DISP    = 8'h0c;
  localparam logic [7:0] B_CLEAR   = 8'h01;
  localparam logic [7:0] B_ENTRY   = 8'h06;
  localparam logic [7:0] B_DDRAM   = 8'h80;
  localparam logic [7:0] B_LINE2   = 8'h40;
  localparam logic [7:0] B_SHR     = 8'd28;
  localparam logic [7:0] B_SHL     = 8'd24;

  localparam logic [7:0] WAIT_PWRUP_NIB = 8'h00;
  localparam logic [7:0] WAIT_CLEAR_NIB = 8'h01;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_WAIT = 1'b1;

  localparam logic WSEL_PWRUP = 1'b0;
  localparam logic WSEL_CLEAR = 1'b1;

  typedef struct packed {
    logic       kind;
    logic       rs;
    logic [7:0] value;
    logic       wsel;
    logic       last;
  } step_t;

  typedef struct packed {
    logic [7:0] pulse;
    logic [7:0] pwrup;
    logic [7:0] clear;
  } cfg_t;

  function automatic step_t lcdn_byte(input logic rs, input logic [7:0] b,
                                      input logic last);
    step_t s;
    s.kind  = KIND_BYTE;
    s.rs    = rs;
    s.value = b;
    s.wsel  = WSEL_PWRUP;
    s.last  = last;
    return s;
  endfunction

  function automatic step_t lcdn_wait(input logic wsel, input logic last);
    step_t s;
    s.kind  = KIND_WAIT;
    s.rs    = 1'b0;
    s.value = (wsel == WSEL_CLEAR) ? WAIT_CLEAR_NIB : WAIT_PWRUP_NIB;
    s.wsel  = wsel;
    s.last  = last;
    return s;
  endfunction

  function automatic step_t lcdn_script(input logic [2:0] op, input logic [7:0] b,
                                        input logic [2:0] idx);
    step_t s;
    s = lcdn_byte(1'b0, b, 1'b1);
    case (op)
      OP_DATA:  s = lcdn_byte(1'b1, b, 1'b1);
      OP_INIT: begin
        case (idx)
          3'd0:    s = lcdn_wait(WSEL_PWRUP, 1'b0);
          3'd1:    s = lcdn_byte(1'b0, B_HOME, 1'b0);
          3'd2:    s = lcdn_byte(1'b0, B_FUNC, 1'b0);
          3'd3:    s = lcdn_byte(1'b0, B_DISP, 1'b0);
          3'd4:    s = lcdn_byte(1'b0, B_CLEAR, 1'b0);
          3'd5:    s = lcdn_wait(WSEL_CLEAR, 1'b0);
          default: s = lcdn_byte(1'b0, B_ENTRY, 1'b1);
        endcase
      end
      OP_CLEAR: begin
        if (idx == 3'd0) begin
          s = lcdn_byte(1'b0, B_CLEAR, 1'b0);
        end else begin
          s = lcdn_wait(WSEL_CLEAR, 1'b1);
        end
      end
      default:  s = lcdn_byte(1'b0, b, 1'b1);
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/char_lcd_nibble_interface.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// Character LCD driver on a 4-bit bus: turns requests into timed pin phases.
//
//   channel  direction  transaction
//   in_*     input      one request (operation, byte, line, column)
//   out_*    output     one pin phase (RS, D7..D4, EN, hold, last)
//   apb      input      register write/read (pulse, power-up, clear waits)
//
// A byte step expands to four pin phases, a wait step to one, in the phase
// generator (lcdn_back). Init spans 22 phases, clear 5 and other operations 4.
// Reset is synchronous, active low; registers return to 1, 50 and 1 ms.
// A stalled output holds the phase while the step queue keeps filling. The
// front end queues one step per cycle, takes the next request once every step
// of the current one is queued, and stalls while the queue is full.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface
  import lcdn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_byte_value,
  input  logic        in_line,
  input  logic [5:0]  in_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_register_select,
  output logic [3:0]  out_data_nibble,
  output logic        out_enable,
  output logic [7:0]  out_hold_ms,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r;
  logic       q_push, q_pop, q_empty, q_full;
  step_t      q_wdata, q_rdata;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse <= PULSE_RST;
      cfg_r.pwrup <= PWRUP_RST;
      cfg_r.clear <= CLEAR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PULSE: cfg_r.pulse <= pwdata[7:0];
        REG_PWRUP: cfg_r.pwrup <= pwdata[7:0];
        REG_CLEAR: cfg_r.clear <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PULSE: prdata = {24'd0, cfg_r.pulse};
      REG_PWRUP: prdata = {24'd0, cfg_r.pwrup};
      REG_CLEAR: prdata = {24'd0, cfg_r.clear};
      default:   prdata = 32'd0;
    endcase
  end

  lcdn_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_byte_value (in_byte_value),
    .in_line       (in_line),
    .in_column     (in_column),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  lcdn_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  lcdn_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_empty             (q_empty),
    .q_rdata             (q_rdata),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_data_nibble     (out_data_nibble),
    .out_enable          (out_enable),
    .out_hold_ms         (out_hold_ms),
    .out_last            (out_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("step queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !q_pop)
    else $error("step queue popped while empty");

  a_en_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enable |-> out_hold_ms == cfg_r.pulse)
    else $error("enable phase hold differs from pulse setting");

  a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_NONE |=> in_ready)
    else $error("unknown operation left front end busy");

endmodule

// ===== rtl/lcdn_front.sv =====
// ----------------------------------------------------------------------------
// lcdn_front
// Accepts requests, resolves the command byte and walks the request script,
// pushing one byte or wait step per cycle into the step queue unless full.
// ----------------------------------------------------------------------------
module lcdn_front
  import lcdn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_byte_value,
  input  logic       in_line,
  input  logic [5:0] in_column,
  input  logic       q_full,
  output logic       q_push,
  output step_t      q_wdata
);

  logic       busy_r, busy_nxt;
  logic [2:0] op_r;
  logic [7:0] byte_r;
  logic [2:0] idx_r, idx_nxt;
  logic       take;
  logic [7:0] curs_byte;

  assign in_ready  = !busy_r;
  assign take      = in_valid && in_ready && (in_operation != OP_NONE);
  assign curs_byte = B_DDRAM + (in_line ? B_LINE2 : 8'h00) + {2'b00, in_column};
  assign q_wdata   = lcdn_script(op_r, byte_r, idx_r);
  assign q_push    = busy_r && !q_full;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_push) begin
      idx_nxt = idx_r + 3'd1;
      if (q_wdata.last) begin
        busy_nxt = 1'b0;
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r   <= in_operation;
      byte_r <= (in_operation == OP_CURS) ? curs_byte :
                (in_operation == OP_SHR)  ? B_SHR :
                (in_operation == OP_SHL)  ? B_SHL : in_byte_value;
    end
  end

endmodule

// ===== rtl/lcdn_queue.sv =====
// ----------------------------------------------------------------------------
// lcdn_queue
// Short step queue between the request front end and the phase generator.
// ----------------------------------------------------------------------------
module lcdn_queue
  import lcdn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  step_t wdata,
  input  logic  pop,
  output step_t rdata,
  output logic  empty,
  output logic  full
);

  step_t          mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign rdata = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/lcdn_back.sv =====
// ----------------------------------------------------------------------------
// lcdn_back
// Expands each step into pin phases (four per byte, one per wait) and holds
// the current phase in the output register.
// ----------------------------------------------------------------------------
module lcdn_back
  import lcdn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  step_t      q_rdata,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_register_select,
  output logic [3:0] out_data_nibble,
  output logic       out_enable,
  output logic [7:0] out_hold_ms,
  output logic       out_last
);

  step_t      cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       rs_r, en_r, last_r;
  logic [3:0] nib_r;
  logic [7:0] hold_r;
  logic       emit, fin;

  assign emit  = cur_valid_r && (!ovalid_r || out_ready);
  assign fin   = emit && ((cur_r.kind == KIND_WAIT) || (ph_r == 2'd3));
  assign q_pop = !q_empty && (!cur_valid_r || fin);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    ph_nxt        = ph_r;
    ovalid_nxt    = ovalid_r;
    if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (emit) begin
      ovalid_nxt = 1'b1;
      ph_nxt     = ph_r + 2'd1;
    end
    if (fin) begin
      cur_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      ph_nxt        = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      ph_r        <= 2'd0;
      ovalid_r    <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      ph_r        <= ph_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
    if (emit) begin
      rs_r   <= cur_r.rs;
      last_r <= fin && cur_r.last;
      if (cur_r.kind == KIND_WAIT) begin
        nib_r  <= cur_r.value[3:0];
        en_r   <= 1'b0;
        hold_r <= (cur_r.wsel == WSEL_CLEAR) ? cfg.clear : cfg.pwrup;
      end else begin
        nib_r  <= ph_r[1] ? cur_r.value[3:0] : cur_r.value[7:4];
        en_r   <= !ph_r[0];
        hold_r <= cfg.pulse;
      end
    end
  end

  assign out_valid           = ovalid_r;
  assign out_register_select = rs_r;
  assign out_data_nibble     = nib_r;
  assign out_enable          = en_r;
  assign out_hold_ms         = hold_r;
  assign out_last            = last_r;

endmodule
